// File: hw/rtl/geohm_pkg.sv
// Shared types, constants and helpers for the geo-gated Hamming matcher.
package geohm_pkg;

  localparam int unsigned REF_DEPTH_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DESC_W   = 256;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned RADIUS_W = 8;
  localparam int unsigned DIST_W   = 10;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] NO_DIST        = 10'd1000;
  localparam logic [DIST_W-1:0] BOUND_SAME     = 10'd88;
  localparam logic [DIST_W-1:0] BOUND_OPPOSITE = 10'd80;
  localparam logic [4:0]        RATIO_DEN      = 5'd20;
  localparam logic [4:0]        RATIO_NUM      = 5'd7;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_X_MIN = 3'd0,
    CFG_BOUND_X_MAX = 3'd1,
    CFG_BOUND_Y_MIN = 3'd2,
    CFG_BOUND_Y_MAX = 3'd3,
    CFG_SEARCH_RADIUS = 3'd4,
    CFG_OPPOSITE_SIDE = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] bound_x_min;
    logic signed [COORD_W-1:0] bound_x_max;
    logic signed [COORD_W-1:0] bound_y_min;
    logic signed [COORD_W-1:0] bound_y_max;
    logic [RADIUS_W-1:0]       search_radius;
    logic                      opposite_side;
  } cfg_t;

  // One classified item passed from the front to the back
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] geo_x;
    logic signed [COORD_W-1:0] geo_y;
    logic [DESC_W-1:0]         desc;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } back_state_t;

  function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] v);
    return 7'($countones(v));
  endfunction

endpackage

// File: hw/rtl/geohm_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface geohm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic signed [geohm_pkg::COORD_W-1:0] geo_x;
  logic signed [geohm_pkg::COORD_W-1:0] geo_y;
  logic [geohm_pkg::WORD_W-1:0]        desc_word0;
  logic [geohm_pkg::WORD_W-1:0]        desc_word1;
  logic [geohm_pkg::WORD_W-1:0]        desc_word2;
  logic [geohm_pkg::WORD_W-1:0]        desc_word3;
  modport source (output valid, operation, geo_x, geo_y, desc_word0, desc_word1,
                  desc_word2, desc_word3, input ready);
  modport sink (input valid, operation, geo_x, geo_y, desc_word0, desc_word1,
                desc_word2, desc_word3, output ready);
endinterface

interface geohm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          matched;
  logic [geohm_pkg::INDEX_W-1:0] match_index;
  logic [geohm_pkg::DIST_W-1:0]  best_distance;
  logic [geohm_pkg::DIST_W-1:0]  second_distance;
  logic [geohm_pkg::COUNT_W-1:0] candidate_count;
  modport source (output valid, matched, match_index, best_distance, second_distance,
                  candidate_count, input ready);
  modport sink (input valid, matched, match_index, best_distance, second_distance,
                candidate_count, output ready);
endinterface

interface geohm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [geohm_pkg::CFG_IDX_W-1:0] index;
  logic [geohm_pkg::COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/geohm_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module geohm_front (
  input  logic                clk,
  input  logic                rst_n,
  geohm_in_if.sink            in_ch,
  output logic                q_valid,
  output geohm_pkg::item_t    q_item,
  input  logic                q_pop
);

  geohm_pkg::item_t q_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  logic             known_op;
  geohm_pkg::item_t item;

  // Classify: unused operation code is dropped at the door
  always_comb begin
    item.op    = geohm_pkg::op_t'(in_ch.operation);
    item.geo_x = in_ch.geo_x;
    item.geo_y = in_ch.geo_y;
    item.desc  = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0};
    known_op   = (item.op == geohm_pkg::OP_CLEAR) || (item.op == geohm_pkg::OP_LOAD) ||
                 (item.op == geohm_pkg::OP_QUERY);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known_op;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop && q_valid) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  // Hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= item;
    end
  end

endmodule

// File: hw/rtl/geohm_back.sv
// Back end: reference store, pipelined scan over references and result register.
module geohm_back #(
  parameter int unsigned REF_DEPTH = geohm_pkg::REF_DEPTH_DEF,
  parameter int unsigned FRAC_BITS = geohm_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  geohm_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  geohm_pkg::item_t    q_item,
  output logic                q_pop,
  geohm_out_if.source         out_ch
);

  localparam int unsigned IDX_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(REF_DEPTH + 1);
  localparam int unsigned CW    = geohm_pkg::COORD_W;
  localparam int unsigned DIFF_W = CW + 1;
  localparam int unsigned SQ_W  = 2 * DIFF_W;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned R_W   = geohm_pkg::RADIUS_W + FRAC_BITS;
  localparam int unsigned R2_W  = 2 * R_W;
  localparam int unsigned DW    = geohm_pkg::DIST_W;

  // Reference store
  logic signed [CW-1:0]           pos_x_mem [REF_DEPTH];
  logic signed [CW-1:0]           pos_y_mem [REF_DEPTH];
  logic [geohm_pkg::DESC_W-1:0]   desc_mem  [REF_DEPTH];
  logic [CNT_W-1:0]               ref_count_r;

  geohm_pkg::back_state_t state_r, state_nxt;

  // Query context
  logic signed [CW-1:0]         qx_r, qy_r;
  logic [geohm_pkg::DESC_W-1:0] qdesc_r;
  logic [R2_W-1:0]              r2_r;
  logic [CNT_W-1:0]             iss_r;
  logic                         iss_v;

  // Scan pipeline
  logic                         v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]             idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [CW-1:0]         rx_r, ry_r;
  logic [geohm_pkg::DESC_W-1:0] rdesc_r;
  logic [DIFF_W-1:0]            dx_r, dy_r;
  logic [geohm_pkg::DESC_W-1:0] xr_r;
  logic [SQ_W-1:0]              sqx_r, sqy_r;
  logic [6:0]                   pc_r [4];
  logic                         cand4_r;
  logic [DW-1:0]                dist4_r;

  // Running results
  logic [DW-1:0]    best_r, second_r;
  logic [IDX_W-1:0] bidx_r;
  logic [CNT_W-1:0] ccnt_r;

  // Output register
  logic                          out_valid_r;
  logic                          matched_r;
  logic [geohm_pkg::INDEX_W-1:0] mindex_r;
  logic [DW-1:0]                 obest_r, osecond_r;
  logic [geohm_pkg::COUNT_W-1:0] ocount_r;

  logic              pop_clear, pop_load, pop_query;
  logic              in_box, scan_done, out_free, do_finish, match_c;
  logic [R_W-1:0]    radius_fx;
  logic [DW-1:0]     bound;
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [SUM_W-1:0]  sq_sum;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == geohm_pkg::ST_IDLE) && q_valid;
  assign pop_clear = q_pop && (q_item.op == geohm_pkg::OP_CLEAR);
  assign pop_load  = q_pop && (q_item.op == geohm_pkg::OP_LOAD);
  assign pop_query = q_pop && (q_item.op == geohm_pkg::OP_QUERY);

  assign in_box = !(q_item.geo_x < cfg.bound_x_min || q_item.geo_y < cfg.bound_y_min ||
                    q_item.geo_x > cfg.bound_x_max || q_item.geo_y > cfg.bound_y_max);
  assign radius_fx = R_W'(cfg.search_radius) << FRAC_BITS;

  assign iss_v     = (state_r == geohm_pkg::ST_SCAN) && (iss_r < ref_count_r);
  assign scan_done = !iss_v && !v1_r && !v2_r && !v3_r && !v4_r;
  assign do_finish = (state_r == geohm_pkg::ST_FINISH) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      geohm_pkg::ST_IDLE: begin
        if (pop_query) begin
          state_nxt = (in_box && ref_count_r != '0) ? geohm_pkg::ST_SCAN
                                                    : geohm_pkg::ST_FINISH;
        end
      end
      geohm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = geohm_pkg::ST_FINISH;
        end
      end
      geohm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = geohm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = geohm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= geohm_pkg::ST_IDLE;
      ref_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop_clear) begin
        ref_count_r <= '0;
      end else if (pop_load && ref_count_r < CNT_W'(REF_DEPTH)) begin
        ref_count_r <= ref_count_r + CNT_W'(1);
      end
    end
  end

  // Write references at the fill count
  always_ff @(posedge clk) begin
    if (pop_load && ref_count_r < CNT_W'(REF_DEPTH)) begin
      pos_x_mem[ref_count_r[IDX_W-1:0]] <= q_item.geo_x;
      pos_y_mem[ref_count_r[IDX_W-1:0]] <= q_item.geo_y;
      desc_mem[ref_count_r[IDX_W-1:0]]  <= q_item.desc;
    end
  end

  // Registered read of the issued reference
  always_ff @(posedge clk) begin
    rx_r    <= pos_x_mem[iss_r[IDX_W-1:0]];
    ry_r    <= pos_y_mem[iss_r[IDX_W-1:0]];
    rdesc_r <= desc_mem[iss_r[IDX_W-1:0]];
  end

  // Latch query context
  always_ff @(posedge clk) begin
    if (pop_query) begin
      qx_r    <= q_item.geo_x;
      qy_r    <= q_item.geo_y;
      qdesc_r <= q_item.desc;
      r2_r    <= R2_W'(radius_fx) * R2_W'(radius_fx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
    end else if (pop_query) begin
      iss_r <= '0;
    end else if (iss_v) begin
      iss_r <= iss_r + CNT_W'(1);
    end
  end

  // Stage 2: absolute differences and descriptor xor
  assign diff_x = DIFF_W'(qx_r) - DIFF_W'(rx_r);
  assign diff_y = DIFF_W'(qy_r) - DIFF_W'(ry_r);

  // Stage 4: squared distance sum
  assign sq_sum = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= iss_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= iss_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    dx_r   <= diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    dy_r   <= diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    xr_r   <= qdesc_r ^ rdesc_r;
    sqx_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
    for (int w = 0; w < 4; w++) begin
      pc_r[w] <= geohm_pkg::popcount64(xr_r[w*geohm_pkg::WORD_W +: geohm_pkg::WORD_W]);
    end
    cand4_r <= sq_sum < SUM_W'(r2_r);
    dist4_r <= DW'(pc_r[0]) + DW'(pc_r[1]) + DW'(pc_r[2]) + DW'(pc_r[3]);
  end

  // Stage 5: keep best and second best
  always_ff @(posedge clk) begin
    if (pop_query) begin
      best_r   <= geohm_pkg::NO_DIST;
      second_r <= geohm_pkg::NO_DIST;
      bidx_r   <= '0;
      ccnt_r   <= '0;
    end else if (v4_r && cand4_r) begin
      ccnt_r <= ccnt_r + CNT_W'(1);
      if (dist4_r < best_r) begin
        second_r <= best_r;
        best_r   <= dist4_r;
        bidx_r   <= idx4_r;
      end else if (dist4_r < second_r) begin
        second_r <= dist4_r;
      end
    end
  end

  // Acceptance test
  always_comb begin
    bound   = cfg.opposite_side ? geohm_pkg::BOUND_OPPOSITE : geohm_pkg::BOUND_SAME;
    match_c = 1'b0;
    if (ccnt_r >= CNT_W'(2) && best_r <= bound &&
        (15'(best_r) * 15'(geohm_pkg::RATIO_DEN)) <=
        (15'(second_r) * 15'(geohm_pkg::RATIO_NUM))) begin
      match_c = 1'b1;
    end else if (ccnt_r == CNT_W'(1) && best_r <= bound) begin
      match_c = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      matched_r <= match_c;
      mindex_r  <= geohm_pkg::INDEX_W'(bidx_r);
      obest_r   <= best_r;
      osecond_r <= second_r;
      ocount_r  <= geohm_pkg::COUNT_W'(ccnt_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.matched         = matched_r;
  assign out_ch.match_index     = mindex_r;
  assign out_ch.best_distance   = obest_r;
  assign out_ch.second_distance = osecond_r;
  assign out_ch.candidate_count = ocount_r;

endmodule

// File: hw/rtl/geo_gated_hamming_ratio_matcher.sv
// Top level: configuration registers, front end, item queue and back end.
//
// Geo-gated Hamming matcher. Items arrive on in_ch: operation 0 clears the
// reference store, 1 loads one reference (ignored once REF_DEPTH are held),
// 2 runs a query; code 3 is dropped. Each query gives one transaction on
// out_ch with the best and second-best Hamming distance among references
// inside the search radius, the best index, the candidate count and the
// ratio-test verdict. cfg_ch writes the bounding box, radius and side flag;
// write it only while the block is idle.
// Clears and loads are taken by the back end while it is idle. A query
// inside the box with N stored references scans them through the single
// read port of the reference store, feeding a five-stage compare pipeline
// one reference per cycle; a query with nothing to scan skips the scan.
// A two-entry queue lets the front accept items while a query runs.
// Reset clears the reference count, the queue and the result register and
// restores default configuration. If out_ch stalls, the result is held and
// the back end waits before issuing the next result; the queue keeps
// accepting until it is full.
module geo_gated_hamming_ratio_matcher #(
  parameter int unsigned REF_DEPTH = geohm_pkg::REF_DEPTH_DEF,
  parameter int unsigned FRAC_BITS = geohm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  geohm_in_if.sink     in_ch,
  geohm_out_if.source  out_ch,
  geohm_cfg_if.sink    cfg_ch
);

  geohm_pkg::cfg_t  cfg_r;
  logic             q_valid, q_pop;
  geohm_pkg::item_t q_item;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bound_x_min   <= 24'sh800000;
      cfg_r.bound_x_max   <= 24'sh7FFFFF;
      cfg_r.bound_y_min   <= 24'sh800000;
      cfg_r.bound_y_max   <= 24'sh7FFFFF;
      cfg_r.search_radius <= 8'd8;
      cfg_r.opposite_side <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (geohm_pkg::cfg_idx_t'(cfg_ch.index))
        geohm_pkg::CFG_BOUND_X_MIN:   cfg_r.bound_x_min   <= cfg_ch.data;
        geohm_pkg::CFG_BOUND_X_MAX:   cfg_r.bound_x_max   <= cfg_ch.data;
        geohm_pkg::CFG_BOUND_Y_MIN:   cfg_r.bound_y_min   <= cfg_ch.data;
        geohm_pkg::CFG_BOUND_Y_MAX:   cfg_r.bound_y_max   <= cfg_ch.data;
        geohm_pkg::CFG_SEARCH_RADIUS: cfg_r.search_radius <= cfg_ch.data[7:0];
        geohm_pkg::CFG_OPPOSITE_SIDE: cfg_r.opposite_side <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  geohm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  geohm_back #(
    .REF_DEPTH (REF_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/geohm_checker.sv
// Port-level checker for the matcher and its bind to the top level.
module geohm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        matched,
  input logic [9:0]  match_index,
  input logic [9:0]  best_distance,
  input logic [9:0]  second_distance,
  input logic [10:0] candidate_count
);

  // Stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped under stall");

  // No candidates means default result
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && candidate_count == 11'd0 |->
      !matched && match_index == 10'd0 && best_distance == 10'd1000 &&
      second_distance == 10'd1000) else $error("empty result not default");

  // A match needs a candidate within the largest bound
  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && matched |-> candidate_count != 11'd0 && best_distance <= 10'd88)
    else $error("match without valid candidate");

  // Single candidate has no second distance
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && candidate_count == 11'd1 |-> second_distance == 10'd1000 &&
      best_distance <= 10'd256) else $error("single candidate result wrong");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind geo_gated_hamming_ratio_matcher geohm_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .matched         (out_ch.matched),
  .match_index     (out_ch.match_index),
  .best_distance   (out_ch.best_distance),
  .second_distance (out_ch.second_distance),
  .candidate_count (out_ch.candidate_count)
);

// File: tb/sv/geo_gated_hamming_ratio_matcher_tb.sv
// Self-checking testbench for the geo-gated Hamming ratio matcher.
`timescale 1ns / 100ps

module geo_gated_hamming_ratio_matcher_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CW = geohm_pkg::COORD_W;
  localparam int unsigned DW = geohm_pkg::DESC_W;
  localparam int unsigned DEPTH = geohm_pkg::REF_DEPTH_DEF;
  localparam int unsigned BIG_LOADS = 200;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic signed [CW-1:0] C_MIN = 24'sh800000;
  localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;

  typedef struct packed {
    logic                            matched;
    logic [geohm_pkg::INDEX_W-1:0]   match_index;
    logic [geohm_pkg::DIST_W-1:0]    best_distance;
    logic [geohm_pkg::DIST_W-1:0]    second_distance;
    logic [geohm_pkg::COUNT_W-1:0]   candidate_count;
  } match_t;

  localparam match_t NO_MATCH = '{1'b0, '0, geohm_pkg::NO_DIST, geohm_pkg::NO_DIST, '0};

  typedef struct {
    logic [1:0]           op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [DW-1:0]        desc;
    bit                   typed;
    match_t               res;
  } row_t;

  logic clk;
  logic rst_n;
  geohm_in_if  in_ch ();
  geohm_out_if out_ch ();
  geohm_cfg_if cfg_ch ();

  geo_gated_hamming_ratio_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the matcher state
  geohm_pkg::cfg_t      cfg_mirror;
  logic signed [CW-1:0] store_x [DEPTH];
  logic signed [CW-1:0] store_y [DEPTH];
  logic [DW-1:0]        store_desc [DEPTH];
  int unsigned          store_count;

  match_t pending_matches [$];
  int     error_count;
  bit     hold_request;
  longint unsigned cycle_count;

  always #1 clk = ~clk;

  function automatic match_t predict_match(logic signed [CW-1:0] qx,
                                           logic signed [CW-1:0] qy,
                                           logic [DW-1:0] qdesc);
    match_t      m;
    longint      dx;
    longint      dy;
    longint      r2;
    int unsigned d;
    int unsigned best;
    int unsigned second;
    int unsigned best_idx;
    int unsigned cnt;
    int unsigned bound;
    bit          ok;
    best = int'(geohm_pkg::NO_DIST);
    second = int'(geohm_pkg::NO_DIST);
    best_idx = 0;
    cnt = 0;
    ok = 0;
    if (!(qx < cfg_mirror.bound_x_min || qy < cfg_mirror.bound_y_min ||
          qx > cfg_mirror.bound_x_max || qy > cfg_mirror.bound_y_max)) begin
      r2 = longint'(cfg_mirror.search_radius) << geohm_pkg::FRAC_BITS_DEF;
      r2 = r2 * r2;
      for (int unsigned i = 0; i < store_count; i++) begin
        dx = longint'(qx) - longint'(store_x[i]);
        dy = longint'(qy) - longint'(store_y[i]);
        if (dx * dx + dy * dy >= r2) continue;
        cnt++;
        d = $countones(qdesc ^ store_desc[i]);
        if (d < best) begin
          second = best;
          best = d;
          best_idx = i;
        end else if (d < second) begin
          second = d;
        end
      end
      bound = cfg_mirror.opposite_side ? int'(geohm_pkg::BOUND_OPPOSITE)
                                       : int'(geohm_pkg::BOUND_SAME);
      if (cnt >= 2 && best <= bound && best * 20 <= second * 7) ok = 1;
      else if (cnt == 1 && best <= bound) ok = 1;
    end
    m.matched = ok;
    m.match_index = best_idx[geohm_pkg::INDEX_W-1:0];
    m.best_distance = best[geohm_pkg::DIST_W-1:0];
    m.second_distance = second[geohm_pkg::DIST_W-1:0];
    m.candidate_count = cnt[geohm_pkg::COUNT_W-1:0];
    return m;
  endfunction

  // Apply an accepted transaction to the mirror and queue its result
  function automatic void track_item(row_t r);
    case (r.op)
      geohm_pkg::OP_CLEAR: store_count = 0;
      geohm_pkg::OP_LOAD: begin
        if (store_count < DEPTH) begin
          store_x[store_count] = r.x;
          store_y[store_count] = r.y;
          store_desc[store_count] = r.desc;
          store_count++;
        end
      end
      geohm_pkg::OP_QUERY:
        pending_matches.insert(pending_matches.size(),
                               r.typed ? r.res : predict_match(r.x, r.y, r.desc));
      default: ;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_desc();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic row_t mk(logic [1:0] op, logic signed [CW-1:0] x,
                              logic signed [CW-1:0] y, logic [DW-1:0] desc,
                              bit typed = 0, match_t res = NO_MATCH);
    row_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.desc = desc;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // Offer one transaction after a random gap, hold until accepted
  task automatic send_item(row_t r);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= r.op;
    in_ch.geo_x <= r.x;
    in_ch.geo_y <= r.y;
    {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0} <= r.desc;
    do @(posedge clk); while (!in_ch.ready);
    track_item(r);
  endtask

  // Drain the block before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(geohm_pkg::cfg_idx_t idx, logic [CW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      geohm_pkg::CFG_BOUND_X_MIN:   cfg_mirror.bound_x_min = data;
      geohm_pkg::CFG_BOUND_X_MAX:   cfg_mirror.bound_x_max = data;
      geohm_pkg::CFG_BOUND_Y_MIN:   cfg_mirror.bound_y_min = data;
      geohm_pkg::CFG_BOUND_Y_MAX:   cfg_mirror.bound_y_max = data;
      geohm_pkg::CFG_SEARCH_RADIUS:
        cfg_mirror.search_radius = data[geohm_pkg::RADIUS_W-1:0];
      default:                      cfg_mirror.opposite_side = data[0];
    endcase
  endtask

  task automatic write_all(logic [CW-1:0] xmin, logic [CW-1:0] xmax,
                           logic [CW-1:0] ymin, logic [CW-1:0] ymax,
                           logic [7:0] radius, logic side);
    wait_idle();
    write_reg(geohm_pkg::CFG_BOUND_X_MIN, xmin);
    write_reg(geohm_pkg::CFG_BOUND_X_MAX, xmax);
    write_reg(geohm_pkg::CFG_BOUND_Y_MIN, ymin);
    write_reg(geohm_pkg::CFG_BOUND_Y_MAX, ymax);
    write_reg(geohm_pkg::CFG_SEARCH_RADIUS, {16'd0, radius});
    write_reg(geohm_pkg::CFG_OPPOSITE_SIDE, {23'd0, side});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [DW-1:0] flip_bits(logic [DW-1:0] d, int n);
    for (int i = 0; i < n; i++) d[$urandom_range(0, DW - 1)] ^= 1'b1;
    return d;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_request = 0;
      end
      stall = $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, out_ch.matched);
          error_count++;
        end
        if (out_ch.match_index !== want.match_index) begin
          $error("match_index: expected %0d, got %0d", want.match_index, out_ch.match_index);
          error_count++;
        end
        if (out_ch.best_distance !== want.best_distance) begin
          $error("best_distance: expected %0d, got %0d", want.best_distance,
                 out_ch.best_distance);
          error_count++;
        end
        if (out_ch.second_distance !== want.second_distance) begin
          $error("second_distance: expected %0d, got %0d", want.second_distance,
                 out_ch.second_distance);
          error_count++;
        end
        if (out_ch.candidate_count !== want.candidate_count) begin
          $error("candidate_count: expected %0d, got %0d", want.candidate_count,
                 out_ch.candidate_count);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("geo_gated_hamming_ratio_matcher_tb: done, errors");
      $finish;
    end
  end

  initial begin
    row_t        directed [$];
    row_t        r;
    logic [DW-1:0] d;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] ymax;
    logic [7:0]  radius;
    int          spread;
    int          nref;
    int          nq;
    int          sent;
    int          phase;

    clk = 0;
    cycle_count = 0;
    error_count = 0;
    hold_request = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= geohm_pkg::OP_CLEAR;
    in_ch.geo_x <= '0;
    in_ch.geo_y <= '0;
    {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= geohm_pkg::CFG_BOUND_X_MIN;
    cfg_ch.data <= '0;
    cfg_mirror = '{C_MIN, C_MAX, C_MIN, C_MAX, 8'd8, 1'b0};
    store_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extremes, ties, unused code, clear
    d = rand_desc();
    directed = {directed, mk(geohm_pkg::OP_QUERY, '0, '0, '0, 1, NO_MATCH)};
    directed = {directed, mk(geohm_pkg::OP_LOAD, '0, '0, '0)};
    directed = {directed, mk(geohm_pkg::OP_LOAD, '0, '0, '1)};
    directed = {directed, mk(geohm_pkg::OP_LOAD, C_MAX, C_MAX, '0)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, '0, '0, '0)};
    directed = {directed, mk(geohm_pkg::OP_LOAD, 24'sh000100, '0, '0)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, '0, '0, '0)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, C_MAX, C_MAX, '1)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, C_MIN, C_MIN, '0, 1, NO_MATCH)};
    directed = {directed, mk(OP_UNUSED, '0, '0, '1)};
    directed = {directed, mk(geohm_pkg::OP_CLEAR, C_MAX, C_MIN, '1)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, '0, '0, '0, 1, NO_MATCH)};
    directed = {directed, mk(geohm_pkg::OP_LOAD, C_MIN, C_MIN, d)};
    directed = {directed, mk(geohm_pkg::OP_QUERY, C_MIN, C_MIN, d, 1,
                             '{1'b1, '0, '0, geohm_pkg::NO_DIST, 11'd1})};
    directed = {directed, mk(geohm_pkg::OP_LOAD, C_MIN + 24'sh000100, C_MIN,
                             flip_bits(d, 20))};
    directed = {directed, mk(geohm_pkg::OP_QUERY, C_MIN, C_MIN, flip_bits(d, 3))};
    directed = {directed, mk(geohm_pkg::OP_QUERY, C_MIN + 24'sh000080, C_MIN,
                             flip_bits(d, 90))};
    foreach (directed[i]) send_item(directed[i]);

    // Load a large store, then query it with a wide radius
    write_all(C_MIN, C_MAX, C_MIN, C_MAX, 8'd255, 1'b1);
    send_item(mk(geohm_pkg::OP_CLEAR, '0, '0, '0));
    for (int i = 0; i < BIG_LOADS; i++)
      send_item(mk(geohm_pkg::OP_LOAD, CW'($urandom_range(0, 'h7FFF)),
                   CW'($urandom_range(0, 'h7FFF)), rand_desc()));
    send_item(mk(geohm_pkg::OP_QUERY, 24'sh004000, 24'sh004000, store_desc[7]));
    send_item(mk(geohm_pkg::OP_QUERY, 24'sh000000, 24'sh000000, rand_desc()));

    // Random phases: configure, clear, load a cluster, query around it
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      cx = CW'($urandom);
      cy = CW'($urandom);
      if (phase % 7 == 1) cx = C_MAX - 24'sh000200;
      if (phase % 7 == 2) cy = C_MIN + 24'sh000200;
      case ($urandom_range(0, 9))
        0: radius = 8'd0;
        1: radius = 8'd255;
        default: radius = 8'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 5))
        0: {xmin, xmax, ymin, ymax} = {cx + 24'sh000400, cx - 24'sh000400, C_MIN, C_MAX};
        1: {xmin, xmax, ymin, ymax} = {cx - 24'sh000300, cx + 24'sh000300,
                                       cy - 24'sh000300, cy + 24'sh000300};
        2: {xmin, xmax, ymin, ymax} = {C_MIN, C_MAX, cy + 24'sh000010, cy - 24'sh000010};
        default: {xmin, xmax, ymin, ymax} = {C_MIN, C_MAX, C_MIN, C_MAX};
      endcase
      write_all(xmin, xmax, ymin, ymax, radius, 1'($urandom_range(0, 1)));
      spread = (int'(radius) + 2) * 256;
      send_item(mk(geohm_pkg::OP_CLEAR, CW'($urandom), CW'($urandom), rand_desc()));
      nref = $urandom_range(1, 12);
      for (int i = 0; i < nref; i++) begin
        if ($urandom_range(0, 3) == 0 && i > 0) d = flip_bits(store_desc[i - 1], 2);
        else d = rand_desc();
        send_item(mk(geohm_pkg::OP_LOAD, CW'(cx + $urandom_range(0, 2 * spread) - spread),
                     CW'(cy + $urandom_range(0, 2 * spread) - spread), d));
      end
      if (phase == 3) hold_request = 1;
      nq = (phase == 3) ? 10 : $urandom_range(2, 8);
      for (int i = 0; i < nq; i++) begin
        case ($urandom_range(0, 9))
          0: r = mk(geohm_pkg::OP_QUERY, CW'($urandom), CW'($urandom), rand_desc());
          1: r = mk(OP_UNUSED, CW'($urandom), CW'($urandom), rand_desc());
          default: r = mk(geohm_pkg::OP_QUERY,
                          CW'(cx + $urandom_range(0, spread) - spread / 2),
                          CW'(cy + $urandom_range(0, spread) - spread / 2),
                          flip_bits(store_desc[$urandom_range(0, store_count - 1)],
                                    $urandom_range(0, 110)));
        endcase
        send_item(r);
      end
      sent += nref + nq + 1;
      phase++;
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (error_count == 0) begin
      $display("geo_gated_hamming_ratio_matcher_tb: done, clean");
    end else begin
      $display("geo_gated_hamming_ratio_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/geohm_pkg.sv
hw/rtl/geohm_if.sv
hw/rtl/geohm_front.sv
hw/rtl/geohm_back.sv
hw/rtl/geo_gated_hamming_ratio_matcher.sv
hw/rtl/geohm_checker.sv
tb/sv/geo_gated_hamming_ratio_matcher_tb.sv
